// ----- src/lru_write_back_block_cache_assert.svh -----
// Assertion macros shared by the block cache RTL.
// Each macro checks on the rising edge of clk and stays quiet while rst is high.
`ifndef LRU_WRITE_BACK_BLOCK_CACHE_ASSERT_SVH
`define LRU_WRITE_BACK_BLOCK_CACHE_ASSERT_SVH
`ifndef SYNTHESIS
`define LWBC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define LWBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LWBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LWBC_ASSERT(lbl, cond, msg)
`define LWBC_ASSERT_IMP(lbl, ante, cons, msg)
`define LWBC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/lwbc_pkg.sv -----
// Types and constants of the LRU write-back block cache.
// No dependencies; every module in the project imports it.
`default_nettype none
package lwbc_pkg;

  localparam int TAG_W  = 32;
  localparam int SLOT_W = 5;
  localparam int RANK_W = 5;
  localparam int AGE_W  = 6;

  // Age that makes every valid entry one older (used on a fill).
  localparam logic [AGE_W-1:0] AGE_FILL = 6'd32;

  typedef enum logic [1:0] {
    FUNC_ACCESS = 2'd0,
    FUNC_MARK   = 2'd1,
    FUNC_SYNC   = 2'd2,
    FUNC_FLUSH  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_HIT     = 3'd0,
    KIND_FETCH   = 3'd1,
    KIND_WB      = 3'd2,
    KIND_ROOT    = 3'd3,
    KIND_MARKED  = 3'd4,
    KIND_IGNORED = 3'd5
  } kind_t;

  typedef struct packed {
    func_t             func;
    logic [TAG_W-1:0]  block_id;
  } req_t;

  typedef struct packed {
    kind_t             kind;
    logic [TAG_W-1:0]  block_id_out;
    logic [SLOT_W-1:0] slot;
    logic              root_synced_out;
    logic              last;
  } rsp_t;

  // Flags from the shared compare unit for the entry under the scan index.
  typedef struct packed {
    logic              hit;
    logic              older;
    logic              newer;
    logic              dirty_newer;
    logic [RANK_W-1:0] rank_inc;
  } cmp_t;

  // Result beat offered by the sequencer to the output register.
  typedef struct packed {
    logic valid;
    rsp_t data;
  } emit_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_MARK,
    S_EV_ROOT,
    S_EV_WB,
    S_TOUCH,
    S_FINISH,
    S_SYNC_SCAN,
    S_SYNC_WB,
    S_SYNC_ROOT
  } state_t;

endpackage
`default_nettype wire

// ----- src/lru_write_back_block_cache.sv -----
// LRU write-back block cache, tag and policy engine.
//
// Request channel (req_valid/req_ready/req): one beat per operation; func selects
// access, mark dirty, sync, or sync then flush, block_id names the block.
// Response channel (rsp_valid/rsp_ready/rsp): one or more beats per request,
// with last set on the final beat of each request.
// One request is worked at a time; req_ready is high only while the sequencer
// is idle, and may be high while the final beat still waits in rsp.
// Each scan of the slots drives one shared compare unit, one slot per cycle.
// A mark dirty has its beat in rsp after the lookup scan, and an access its hit
// or fetch beat after the lookup scan and a touch scan; a root write or write
// back on eviction follows the lookup scan and delays the fetch beat. A sync
// runs one scan per dirty entry, each followed by its write back, then a last
// scan and the root write. req_ready rises in the cycle after the final beat
// is loaded into rsp.
// A stalled receiver holds the sequencer at its next beat; nothing is dropped.
// Reset empties the cache and clears the synced mark; no clearing pass is run.
// Depends on lwbc_pkg, lwbc_ctrl and lwbc_cmp.
`default_nettype none
module lru_write_back_block_cache #(
  parameter int CACHE_ENTRIES = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire lwbc_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output lwbc_pkg::rsp_t      rsp
);
  import lwbc_pkg::*;

  logic  out_free;
  logic  rsp_valid_next;
  emit_t emit;

  // the output register takes a beat when empty or drained this cycle
  assign out_free = !rsp_valid || rsp_ready;

  lwbc_ctrl #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_free  (out_free),
    .emit      (emit)
  );

  always_comb begin
    if (emit.valid) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) rsp <= emit.data;
  end

endmodule
`default_nettype wire

// ----- src/lwbc_cmp.sv -----
// Shared compare unit: tag match, age compare, victim compare and rank increment
// for one cache entry. Depends on lwbc_pkg.
`default_nettype none
module lwbc_cmp (
  input  wire logic [lwbc_pkg::TAG_W-1:0]  key,
  input  wire logic [lwbc_pkg::TAG_W-1:0]  tag,
  input  wire logic                        valid,
  input  wire logic                        dirty,
  input  wire logic [lwbc_pkg::RANK_W-1:0] rank,
  input  wire logic [lwbc_pkg::AGE_W-1:0]  age,
  input  wire logic                        best_found,
  input  wire logic [lwbc_pkg::RANK_W-1:0] best_rank,
  output lwbc_pkg::cmp_t                   res
);
  import lwbc_pkg::*;

  logic newer;

  assign newer = valid && (!best_found || (rank > best_rank));

  always_comb begin
    res.hit         = valid && (tag == key);
    res.older       = valid && ({1'b0, rank} < age);
    res.newer       = newer;
    res.dirty_newer = newer && dirty;
    res.rank_inc    = rank + RANK_W'(1);
  end

endmodule
`default_nettype wire

// ----- src/lwbc_ctrl.sv -----
// Sequencer of the block cache: tag and rank stores, valid and dirty bits, and the
// scans that drive the shared compare unit. Depends on lwbc_pkg and lwbc_cmp.
`default_nettype none
module lwbc_ctrl #(
  parameter int CACHE_ENTRIES = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire lwbc_pkg::req_t req,
  input  wire logic           out_free,
  output lwbc_pkg::emit_t     emit
);
  import lwbc_pkg::*;

  localparam int IW = $clog2(CACHE_ENTRIES);
  localparam int CW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(CACHE_ENTRIES - 1);

  state_t state, state_next;

  logic [TAG_W-1:0]  tag_mem  [CACHE_ENTRIES];
  logic [RANK_W-1:0] rank_mem [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] valid_bits;
  logic [CACHE_ENTRIES-1:0] dirty_bits;
  logic [CW-1:0] entry_count;
  logic          root_synced;

  func_t            func;
  logic [TAG_W-1:0] key;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    tgt;
  logic [AGE_W-1:0] age;
  logic             fill;
  logic             hit_found;
  logic [IW-1:0]    hit_slot;
  logic             free_found;
  logic [IW-1:0]    free_slot;
  logic              best_found;
  logic [IW-1:0]     best_slot;
  logic [RANK_W-1:0] best_rank;
  logic              best_dirty;
  logic [TAG_W-1:0]  best_tag;

  logic [TAG_W-1:0]  tag_rd;
  logic [RANK_W-1:0] rank_rd;
  logic              scan_last;
  cmp_t              cmp;

  assign tag_rd    = tag_mem[idx];
  assign rank_rd   = rank_mem[idx];
  assign scan_last = (idx == IDX_LAST);

  lwbc_cmp u_cmp (
    .key        (key),
    .tag        (tag_rd),
    .valid      (valid_bits[idx]),
    .dirty      (dirty_bits[idx]),
    .rank       (rank_rd),
    .age        (age),
    .best_found (best_found),
    .best_rank  (best_rank),
    .res        (cmp)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.func == FUNC_ACCESS || req.func == FUNC_MARK) begin
            state_next = S_LOOKUP;
          end else begin
            state_next = S_SYNC_SCAN;
          end
        end
      end
      S_LOOKUP: begin
        if (scan_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (func == FUNC_MARK) begin
          state_next = S_MARK;
        end else if (hit_found || free_found || !best_dirty) begin
          state_next = S_TOUCH;
        end else if (root_synced) begin
          state_next = S_EV_ROOT;
        end else begin
          state_next = S_EV_WB;
        end
      end
      S_MARK: begin
        if (out_free) state_next = S_IDLE;
      end
      S_EV_ROOT: begin
        if (out_free) state_next = S_EV_WB;
      end
      S_EV_WB: begin
        if (out_free) state_next = S_TOUCH;
      end
      S_TOUCH: begin
        if (scan_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      S_SYNC_SCAN: begin
        if (scan_last) begin
          state_next = (best_found || cmp.dirty_newer) ? S_SYNC_WB : S_SYNC_ROOT;
        end
      end
      S_SYNC_WB: begin
        if (out_free) state_next = S_SYNC_SCAN;
      end
      S_SYNC_ROOT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready = (state == S_IDLE);
    emit      = '0;
    unique case (state)
      S_MARK: begin
        emit.valid             = out_free;
        emit.data.kind         = hit_found ? KIND_MARKED : KIND_IGNORED;
        emit.data.block_id_out = key;
        emit.data.slot         = hit_found ? SLOT_W'(hit_slot) : '0;
        emit.data.last         = 1'b1;
      end
      S_EV_ROOT: begin
        emit.valid     = out_free;
        emit.data.kind = KIND_ROOT;
      end
      S_EV_WB, S_SYNC_WB: begin
        emit.valid             = out_free;
        emit.data.kind         = KIND_WB;
        emit.data.block_id_out = best_tag;
        emit.data.slot         = SLOT_W'(best_slot);
      end
      S_FINISH: begin
        emit.valid             = out_free;
        emit.data.kind         = hit_found ? KIND_HIT : KIND_FETCH;
        emit.data.block_id_out = key;
        emit.data.slot         = SLOT_W'(tgt);
        emit.data.last         = 1'b1;
      end
      S_SYNC_ROOT: begin
        emit.valid                = out_free;
        emit.data.kind            = KIND_ROOT;
        emit.data.root_synced_out = 1'b1;
        emit.data.last            = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Valid, dirty, fill count and synced mark
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits  <= '0;
      dirty_bits  <= '0;
      entry_count <= '0;
      root_synced <= 1'b0;
    end else begin
      case (state)
        S_MARK: begin
          if (out_free && hit_found) dirty_bits[hit_slot] <= 1'b1;
        end
        S_EV_ROOT: begin
          if (out_free) root_synced <= 1'b0;
        end
        S_EV_WB: begin
          if (out_free) dirty_bits[tgt] <= 1'b0;
        end
        S_FINISH: begin
          if (out_free && fill) begin
            valid_bits[tgt] <= 1'b1;
            dirty_bits[tgt] <= 1'b0;
            entry_count     <= entry_count + CW'(1);
          end
        end
        S_SYNC_WB: begin
          if (out_free) dirty_bits[best_slot] <= 1'b0;
        end
        S_SYNC_ROOT: begin
          if (out_free) begin
            root_synced <= 1'b1;
            if (func == FUNC_FLUSH) begin
              valid_bits  <= '0;
              dirty_bits  <= '0;
              entry_count <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Scan index and per-item working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          func       <= req.func;
          key        <= req.block_id;
          idx        <= '0;
          hit_found  <= 1'b0;
          free_found <= 1'b0;
          best_found <= 1'b0;
        end
      end
      S_LOOKUP: begin
        if (cmp.hit && !hit_found) begin
          hit_found <= 1'b1;
          hit_slot  <= idx;
          age       <= {1'b0, rank_rd};
        end
        if (!valid_bits[idx] && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= idx;
        end
        if (cmp.newer) begin
          best_found <= 1'b1;
          best_slot  <= idx;
          best_rank  <= rank_rd;
          best_dirty <= dirty_bits[idx];
          best_tag   <= tag_rd;
        end
        idx <= scan_last ? '0 : idx + IW'(1);
      end
      S_DECIDE: begin
        idx  <= '0;
        fill <= 1'b0;
        if (hit_found) begin
          tgt <= hit_slot;
        end else if (free_found) begin
          tgt  <= free_slot;
          age  <= AGE_FILL;
          fill <= 1'b1;
        end else begin
          tgt <= best_slot;
          age <= {1'b0, best_rank};
        end
      end
      S_TOUCH: begin
        idx <= scan_last ? '0 : idx + IW'(1);
      end
      S_SYNC_SCAN: begin
        // oldest dirty entry wins; ranks of valid entries are distinct
        if (cmp.dirty_newer) begin
          best_found <= 1'b1;
          best_slot  <= idx;
          best_rank  <= rank_rd;
          best_tag   <= tag_rd;
        end
        idx <= scan_last ? '0 : idx + IW'(1);
      end
      S_SYNC_WB: begin
        if (out_free) begin
          best_found <= 1'b0;
          idx        <= '0;
        end
      end
      default: ;
    endcase
  end

  // Tag and rank stores
  always_ff @(posedge clk) begin
    case (state)
      S_TOUCH: begin
        if (cmp.older && idx != tgt) rank_mem[idx] <= cmp.rank_inc;
      end
      S_FINISH: begin
        if (out_free) begin
          rank_mem[tgt] <= '0;
          if (!hit_found) tag_mem[tgt] <= key;
        end
      end
      default: ;
    endcase
  end

`include "lru_write_back_block_cache_assert.svh"
  `LWBC_ASSERT(a_count_bound, int'(entry_count) <= CACHE_ENTRIES, "entry count overflow")
  `LWBC_ASSERT(a_count_match, $countones(valid_bits) == int'(entry_count), "count mismatch")
  `LWBC_ASSERT(a_dirty_valid, (dirty_bits & ~valid_bits) == '0, "dirty bit on invalid slot")
  `LWBC_ASSERT_NXT(a_last_idle, emit.valid && emit.data.last, state == S_IDLE, "no idle after last")

endmodule
`default_nettype wire

// ----- test/tb_lru_write_back_block_cache.sv -----
// Self-checking bench for the LRU write-back block cache: a directed table, then random
// operations over a small id pool, checked beat by beat against a behavioral cache model.
// Depends on lwbc_pkg and lru_write_back_block_cache.
module tb_lru_write_back_block_cache;
  import lwbc_pkg::*;

  localparam int ENTRIES      = 32;
  localparam int RANDOM_OPS   = 185;
  localparam int POOL         = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
  localparam int NUM_DIRECTED = 25;

  typedef struct packed {
    func_t       op;
    logic [31:0] id;
    logic        typed;
    kind_t       k;
    logic [4:0]  slot;
    logic        synced;
  } step_row_t;

  // Rows with typed set carry their single, obvious result beat.
  localparam step_row_t DIRECTED [NUM_DIRECTED] = '{
    '{FUNC_SYNC,   32'h0000_0000, 1'b1, KIND_ROOT,    5'd0, 1'b1},
    '{FUNC_MARK,   32'hFFFF_FFFF, 1'b1, KIND_IGNORED, 5'd0, 1'b0},
    '{FUNC_ACCESS, 32'h0000_0000, 1'b1, KIND_FETCH,   5'd0, 1'b0},
    '{FUNC_ACCESS, 32'hFFFF_FFFF, 1'b1, KIND_FETCH,   5'd1, 1'b0},
    '{FUNC_ACCESS, 32'h0000_0000, 1'b1, KIND_HIT,     5'd0, 1'b0},
    '{FUNC_MARK,   32'h0000_0000, 1'b1, KIND_MARKED,  5'd0, 1'b0},
    '{FUNC_ACCESS, 32'h8000_0000, 1'b1, KIND_FETCH,   5'd2, 1'b0},
    '{FUNC_MARK,   32'hFFFF_FFFF, 1'b1, KIND_MARKED,  5'd1, 1'b0},
    '{FUNC_ACCESS, 32'h7FFF_FFFF, 1'b1, KIND_FETCH,   5'd3, 1'b0},
    '{FUNC_SYNC,   32'h1234_5678, 1'b0, KIND_HIT,     5'd0, 1'b0},
    '{FUNC_MARK,   32'h8000_0000, 1'b1, KIND_MARKED,  5'd2, 1'b0},
    '{FUNC_MARK,   32'h0000_0000, 1'b1, KIND_MARKED,  5'd0, 1'b0},
    '{FUNC_ACCESS, 32'h7FFF_FFFF, 1'b1, KIND_HIT,     5'd3, 1'b0},
    '{FUNC_FLUSH,  32'hFFFF_FFFF, 1'b0, KIND_HIT,     5'd0, 1'b0},
    '{FUNC_FLUSH,  32'h0000_0000, 1'b1, KIND_ROOT,    5'd0, 1'b1},
    '{FUNC_MARK,   32'h0000_0000, 1'b1, KIND_IGNORED, 5'd0, 1'b0},
    '{FUNC_ACCESS, 32'h5555_5555, 1'b1, KIND_FETCH,   5'd0, 1'b0},
    '{FUNC_ACCESS, 32'hAAAA_AAAA, 1'b1, KIND_FETCH,   5'd1, 1'b0},
    '{FUNC_ACCESS, 32'h0000_0000, 1'b1, KIND_FETCH,   5'd2, 1'b0},
    '{FUNC_MARK,   32'hAAAA_AAAA, 1'b1, KIND_MARKED,  5'd1, 1'b0},
    '{FUNC_ACCESS, 32'h5555_5555, 1'b1, KIND_HIT,     5'd0, 1'b0},
    '{FUNC_SYNC,   32'h0000_0000, 1'b0, KIND_HIT,     5'd0, 1'b0},
    '{FUNC_ACCESS, 32'hFFFF_FFFF, 1'b1, KIND_FETCH,   5'd3, 1'b0},
    '{FUNC_MARK,   32'h5555_5555, 1'b1, KIND_MARKED,  5'd0, 1'b0},
    '{FUNC_ACCESS, 32'h0000_0000, 1'b1, KIND_HIT,     5'd2, 1'b0}
  };

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  lru_write_back_block_cache #(
    .CACHE_ENTRIES(ENTRIES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  // Cache model state
  logic [31:0] line_tag [ENTRIES];
  bit          line_valid [ENTRIES];
  bit          line_dirty [ENTRIES];
  logic [4:0]  line_age [ENTRIES];
  int unsigned line_count;
  bit          root_synced_mark;

  rsp_t op_beats[$];
  rsp_t expected_beats[$];
  int   kind_count [6];
  int   dirty_evictions;

  bit   row_typed;
  rsp_t row_want;
  bit   steady;
  bit   hold_armed;
  int   hold_left;

  int   mismatches;
  int   beats_checked;
  int   ops_accepted;
  int   cycle_count;
  logic [31:0] id_pool [POOL];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at beat %0d, %s: got %0h, expected %0h", beats_checked, field, got,
               want);
  endtask

  function automatic int find_line(logic [31:0] id);
    for (int i = 0; i < ENTRIES; i++)
      if (line_valid[i] && line_tag[i] == id) return i;
    return -1;
  endfunction

  // Make slot s the most recent; valid entries younger than age grow one older.
  function automatic void promote(int s, int unsigned age);
    for (int i = 0; i < ENTRIES; i++)
      if (line_valid[i] && i != s && line_age[i] < age) line_age[i] = line_age[i] + 5'd1;
    line_age[s] = '0;
  endfunction

  function automatic void queue_beat(kind_t k, logic [31:0] id, int s, bit mark);
    rsp_t b;
    b.kind            = k;
    b.block_id_out    = id;
    b.slot            = 5'(s);
    b.root_synced_out = mark;
    b.last            = 1'b0;
    op_beats.push_back(b);
    kind_count[k]++;
  endfunction

  function automatic void predict_access(logic [31:0] id);
    int s;
    s = find_line(id);
    if (s >= 0) begin
      promote(s, line_age[s]);
      queue_beat(KIND_HIT, id, s, 1'b0);
      return;
    end
    if (line_count < ENTRIES)
      for (int i = 0; i < ENTRIES && s < 0; i++)
        if (!line_valid[i]) s = i;
    if (s >= 0) begin
      promote(s, ENTRIES);
      line_valid[s] = 1'b1;
      line_dirty[s] = 1'b0;
      line_count++;
    end else begin
      for (int i = 0; i < ENTRIES; i++)
        if (line_valid[i] && (s < 0 || line_age[i] > line_age[s])) s = i;
      if (line_dirty[s]) begin
        // First dirty eviction after a sync clears the synced mark on disk.
        if (root_synced_mark) begin
          root_synced_mark = 1'b0;
          queue_beat(KIND_ROOT, '0, 0, 1'b0);
        end
        queue_beat(KIND_WB, line_tag[s], s, 1'b0);
        line_dirty[s] = 1'b0;
        dirty_evictions++;
      end
      promote(s, line_age[s]);
      line_valid[s] = 1'b1;
    end
    line_tag[s] = id;
    queue_beat(KIND_FETCH, id, s, 1'b0);
  endfunction

  // Write back dirty entries, oldest first, then the root with the mark set.
  function automatic void write_back_all();
    for (int r = ENTRIES - 1; r >= 0; r--)
      for (int i = 0; i < ENTRIES; i++)
        if (line_valid[i] && line_dirty[i] && line_age[i] == 5'(r)) begin
          queue_beat(KIND_WB, line_tag[i], i, 1'b0);
          line_dirty[i] = 1'b0;
        end
    root_synced_mark = 1'b1;
    queue_beat(KIND_ROOT, '0, 0, 1'b1);
  endfunction

  function automatic void predict_op(func_t op, logic [31:0] id);
    int s;
    op_beats.delete();
    case (op)
      FUNC_ACCESS: predict_access(id);
      FUNC_MARK: begin
        s = find_line(id);
        if (s >= 0) begin
          line_dirty[s] = 1'b1;
          queue_beat(KIND_MARKED, id, s, 1'b0);
        end else begin
          queue_beat(KIND_IGNORED, id, 0, 1'b0);
        end
      end
      default: begin
        write_back_all();
        if (op == FUNC_FLUSH) begin
          for (int i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
          end
          line_count = 0;
        end
      end
    endcase
    op_beats[op_beats.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        predict_op(req.func, req.block_id);
        if (row_typed) expected_beats.push_back(row_want);
        else foreach (op_beats[i]) expected_beats.push_back(op_beats[i]);
        ops_accepted++;
      end
      if (rsp_valid && rsp_ready) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          note_mismatch("beat with nothing expected", rsp.block_id_out, '0);
        end else begin
          want = expected_beats.pop_front();
          if (rsp.kind !== want.kind) note_mismatch("kind", 32'(rsp.kind), 32'(want.kind));
          if (rsp.block_id_out !== want.block_id_out)
            note_mismatch("block_id_out", rsp.block_id_out, want.block_id_out);
          if (rsp.slot !== want.slot) note_mismatch("slot", 32'(rsp.slot), 32'(want.slot));
          if (rsp.root_synced_out !== want.root_synced_out)
            note_mismatch("root_synced_out", 32'(rsp.root_synced_out),
                          32'(want.root_synced_out));
          if (rsp.last !== want.last) note_mismatch("last", 32'(rsp.last), 32'(want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
               expected_beats.size());
      $display("status: fail");
      $finish;
    end
  end

  // Response side: random stalls, a quiet stretch, and one long hold-off.
  initial begin
    rsp_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (steady) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= 10);
      end
    end
  end

  // Offer one beat at a falling edge and hold it until accepted.
  task automatic offer(func_t op, logic [31:0] id, bit typed, rsp_t want);
    int gap;
    if (!steady && $urandom_range(99) < 10) begin
      req_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    req.func     <= op;
    req.block_id <= id;
    req_valid    <= 1'b1;
    row_typed = typed;
    row_want  = want;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    rsp_t        want;
    step_row_t   row;
    func_t       op;
    logic [31:0] id;
    int          pick;
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    steady       = 1'b0;
    hold_armed   = 1'b0;
    row_typed    = 1'b0;
    row_want     = '0;
    line_count   = 0;
    root_synced_mark = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
    end
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL; i++) id_pool[i] = $urandom;

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int n = 0; n < NUM_DIRECTED; n++) begin
      row = DIRECTED[n];
      want.kind            = row.k;
      want.block_id_out    = (row.k == KIND_ROOT) ? '0 : row.id;
      want.slot            = row.slot;
      want.root_synced_out = row.synced;
      want.last            = 1'b1;
      offer(row.op, row.id, row.typed, want);
    end

    // Drain before the random part starts.
    req_valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);

    want = '0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      steady = (n >= 120 && n < 170);
      if (n == 30) hold_armed = 1'b1;
      if (n == 90) begin
        req_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 60) op = FUNC_ACCESS;
      else if (pick < 85) op = FUNC_MARK;
      else if (pick < 98 || n < 100) op = FUNC_SYNC;
      else op = FUNC_FLUSH;
      // Mostly pool ids so the cache fills and evicts; now and then a fresh one.
      id = ($urandom_range(19) == 0) ? $urandom : id_pool[$urandom_range(POOL - 1)];
      offer(op, id, 1'b0, want);
    end
    req_valid <= 1'b0;
    steady = 1'b0;

    while (expected_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("ran %0d requests (%0d directed), checked %0d response beats, %0d mismatches",
             ops_accepted, NUM_DIRECTED, beats_checked, mismatches);
    $display("hits %0d, fetches %0d, write backs %0d, root writes %0d, dirty evictions %0d",
             kind_count[KIND_HIT], kind_count[KIND_FETCH], kind_count[KIND_WB],
             kind_count[KIND_ROOT], dirty_evictions);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/lwbc_pkg.sv
src/lwbc_cmp.sv
src/lwbc_ctrl.sv
src/lru_write_back_block_cache.sv
test/tb_lru_write_back_block_cache.sv
